// ===== hdl/i2c_master_bit_engine_defines.svh =====
// Assertion macros shared by the checker of the I2C master bit engine.
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Beat types, command codes, engine state and small timing helpers.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [2:0] K_TICK  = 3'd0;
    localparam logic [2:0] K_START = 3'd1;
    localparam logic [2:0] K_STOP  = 3'd2;
    localparam logic [2:0] K_WRITE = 3'd3;
    localparam logic [2:0] K_READ  = 3'd4;

    localparam logic [7:0] MSB_MASK = 8'h80;

    localparam logic [4:0] LEN_START = 5'd4;
    localparam logic [4:0] LEN_STOP  = 5'd2;
    localparam logic [4:0] LEN_WRITE = 5'd27;
    localparam logic [4:0] LEN_READ  = 5'd19;

    // Write phases: 24 data ticks, then SDA release, SCL high, ack sample.
    localparam logic [4:0] WR_LAST_BIT = 5'd23;
    localparam logic [4:0] WR_RELEASE  = 5'd24;
    localparam logic [4:0] WR_ACK_HIGH = 5'd25;
    // Read phases: 16 sample ticks, then ack drive, SCL high, SCL low.
    localparam logic [4:0] RD_ACK_DRIVE = 5'd16;
    localparam logic [4:0] RD_ACK_HIGH  = 5'd17;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       drive_ack;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       nack;
        logic       cmd_ignored;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_IDLE  = 5'b00001,
        OP_START = 5'b00010,
        OP_STOP  = 5'b00100,
        OP_WRITE = 5'b01000,
        OP_READ  = 5'b10000
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] phase;
        logic [7:0] shift_byte;
        logic [7:0] rx_byte;
        logic       ack_choice;
        logic       scl_level;
        logic       sda_level;
        logic       nack_flag;
    } t_state;

    function automatic logic [4:0] op_last_phase(input t_op op);
        logic [4:0] len;
        case (op)
            OP_START: len = LEN_START;
            OP_STOP:  len = LEN_STOP;
            OP_WRITE: len = LEN_WRITE;
            OP_READ:  len = LEN_READ;
            default:  len = 5'd1;
        endcase
        return len - 5'd1;
    endfunction

    // Position of a write data tick within its three-tick bit slot.
    function automatic logic [1:0] wr_sub(input logic [4:0] p);
        logic [1:0] sub;
        case (p) inside
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21:   sub = 2'd0;
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22:  sub = 2'd1;
            default:                                              sub = 2'd2;
        endcase
        return sub;
    endfunction

endpackage

// ===== hdl/i2cm_tick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master tick logic
// Computes the next engine state and the result beat for one tick.
// ----------------------------------------------------------------------------
module i2cm_tick (
    input  i2cm_pkg::t_state    i_state,
    input  i2cm_pkg::t_in_item  i_item,
    output i2cm_pkg::t_state    o_state,
    output i2cm_pkg::t_out_item o_item
);
    import i2cm_pkg::*;

    t_state     st;
    logic       is_cmd;
    logic       busy;
    logic       done;
    logic       ignored;
    logic [4:0] p;

    always_comb begin
        st      = i_state;
        busy    = 1'b0;
        done    = 1'b0;
        ignored = 1'b0;
        is_cmd  = (i_item.kind inside {[K_START:K_READ]});

        // An idle engine takes the command and runs its first tick at once.
        if (i_state.op == OP_IDLE) begin
            if (is_cmd) begin
                st.phase = 5'd0;
                case (i_item.kind)
                    K_START: st.op = OP_START;
                    K_STOP:  st.op = OP_STOP;
                    K_WRITE: begin
                        st.op         = OP_WRITE;
                        st.shift_byte = i_item.data;
                    end
                    default: begin
                        st.op         = OP_READ;
                        st.shift_byte = 8'd0;
                        st.ack_choice = i_item.drive_ack;
                    end
                endcase
            end
        end else if (is_cmd) begin
            ignored = 1'b1;
        end

        p = st.phase;
        case (st.op)
            OP_START: begin
                case (p)
                    5'd0:    st.sda_level = 1'b1;
                    5'd1:    st.scl_level = 1'b1;
                    5'd2:    st.sda_level = 1'b0;
                    default: st.scl_level = 1'b0;
                endcase
            end
            OP_STOP: begin
                if (p == 5'd0) begin
                    st.sda_level = 1'b0;
                    st.scl_level = 1'b1;
                end else begin
                    st.sda_level = 1'b1;
                end
            end
            OP_WRITE: begin
                if (p < WR_RELEASE) begin
                    case (wr_sub(p))
                        2'd0:    st.sda_level = |(st.shift_byte & MSB_MASK);
                        2'd1:    st.scl_level = 1'b1;
                        default: begin
                            st.scl_level  = 1'b0;
                            st.shift_byte = {st.shift_byte[6:0], 1'b0};
                            if (p == WR_LAST_BIT) begin
                                st.sda_level = 1'b1;
                            end
                        end
                    endcase
                end else if (p == WR_RELEASE) begin
                    st.sda_level = 1'b1;
                end else if (p == WR_ACK_HIGH) begin
                    st.scl_level = 1'b1;
                end else begin
                    st.nack_flag = i_item.sda_in;
                    st.scl_level = 1'b0;
                end
            end
            OP_READ: begin
                if (p < RD_ACK_DRIVE) begin
                    if (!p[0]) begin
                        st.scl_level = 1'b1;
                    end else begin
                        st.shift_byte = {st.shift_byte[6:0], i_item.sda_in};
                        st.scl_level  = 1'b0;
                    end
                end else if (p == RD_ACK_DRIVE) begin
                    st.sda_level = !st.ack_choice;
                end else if (p == RD_ACK_HIGH) begin
                    st.scl_level = 1'b1;
                end else begin
                    st.scl_level = 1'b0;
                    if (st.ack_choice) begin
                        st.sda_level = 1'b1;
                    end
                    st.rx_byte = st.shift_byte;
                end
            end
            default: begin
            end
        endcase

        if (st.op != OP_IDLE) begin
            busy = 1'b1;
            if (p == op_last_phase(st.op)) begin
                done     = 1'b1;
                st.op    = OP_IDLE;
                st.phase = 5'd0;
            end else begin
                st.phase = p + 5'd1;
            end
        end
    end

    assign o_state = st;

    always_comb begin
        o_item.scl_out     = st.scl_level;
        o_item.sda_out     = st.sda_level;
        o_item.busy_res    = busy;
        o_item.done_res    = done;
        o_item.read_data   = st.rx_byte;
        o_item.nack        = st.nack_flag;
        o_item.cmd_ignored = ignored;
    end

endmodule

// ===== hdl/i2c_master_bit_engine.sv =====
`timescale 1ns / 1ps
// Each result beat is registered and shown in the cycle after its input beat is accepted.
// Throughput: one tick per cycle unless a result stalls; the whole tick update
// is a single pass of the tick logic into the state and output registers.
// Reset: synchronous, active low; both lines released high, engine idle,
// no result beat pending.
// ----------------------------------------------------------------------------
// I2C master bit engine
// Runs start, stop, write and read commands one tick per beat.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  i2cm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output i2cm_pkg::t_out_item o_out_item
);
    import i2cm_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      in_accept;

    i2cm_tick u_tick (
        .i_state (r_state),
        .i_item  (i_in_item),
        .o_state (n_state),
        .o_item  (n_out)
    );

    // The output register frees up in the same cycle its beat is taken.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.op         <= OP_IDLE;
            r_state.phase      <= 5'd0;
            r_state.shift_byte <= 8'd0;
            r_state.rx_byte    <= 8'd0;
            r_state.ack_choice <= 1'b0;
            r_state.scl_level  <= 1'b1;
            r_state.sda_level  <= 1'b1;
            r_state.nack_flag  <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            if (in_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== hdl/i2cm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Port-level checks on the result register and the input and output handshakes.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_defines.svh"

module i2cm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input i2cm_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input i2cm_pkg::t_out_item o_out_item
);
    import i2cm_pkg::*;

    logic out_stall;
    logic in_stall;

    assign out_stall = o_out_valid && !i_out_ready;
    assign in_stall  = i_in_valid && !o_in_ready;

    `I2CM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_item), "result beat changed while stalled")
    `I2CM_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_stall, i_in_valid && $stable(i_in_item), "input beat changed while waiting")
    `I2CM_ASSERT_IMPL(a_empty_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input blocked with an empty result register")
    `I2CM_ASSERT_IMPL(a_stall_blocks, i_clk, i_rst_n, out_stall, !o_in_ready, "input taken while a result beat is stalled")
    `I2CM_ASSERT_IMPL(a_done_busy, i_clk, i_rst_n, o_out_valid && (o_out_item.done_res || o_out_item.cmd_ignored), o_out_item.busy_res, "done or ignored flag without busy")

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/i2c_master_bit_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Feeds tick beats (start, stop, write, read commands with their
// tick trains, plus noise and commands issued while busy) and checks every
// result beat against a tick-level model of the SCL/SDA waveform engine.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
    import i2cm_pkg::*;

    localparam int RANDOM_ITEMS = 720;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    t_in_item  tick_queue[$];
    t_out_item expected_ticks[$];

    int total_items = 1;
    int n_accepted = 0;
    int n_checked = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit stall_done = 1'b0;

    // Model of the engine state.
    t_op        m_op = OP_IDLE;
    int         m_phase = 0;
    int         m_len = 0;
    logic [7:0] m_shift = '0;
    logic [7:0] m_rx = '0;
    logic       m_ack_choice = 1'b0;
    logic       m_scl = 1'b1;
    logic       m_sda = 1'b1;
    logic       m_nack = 1'b0;

    i2c_master_bit_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int command_length(input logic [2:0] kind);
        case (kind)
            K_START: return int'(LEN_START);
            K_STOP:  return int'(LEN_STOP);
            K_WRITE: return int'(LEN_WRITE);
            default: return int'(LEN_READ);
        endcase
    endfunction

    // Advances the engine model by one tick and returns the expected result.
    function automatic t_out_item bus_tick(input t_in_item it);
        t_out_item r;
        logic      is_cmd;
        int        p;
        r = '0;
        is_cmd = (it.kind >= K_START) && (it.kind <= K_READ);
        if (m_op == OP_IDLE) begin
            if (is_cmd) begin
                m_len = command_length(it.kind);
                m_phase = 0;
                case (it.kind)
                    K_START: m_op = OP_START;
                    K_STOP:  m_op = OP_STOP;
                    K_WRITE: begin
                        m_op = OP_WRITE;
                        m_shift = it.data;
                    end
                    default: begin
                        m_op = OP_READ;
                        m_shift = '0;
                        m_ack_choice = it.drive_ack;
                    end
                endcase
            end
        end else if (is_cmd) begin
            r.cmd_ignored = 1'b1;
        end

        if (m_op != OP_IDLE) begin
            p = m_phase;
            r.busy_res = 1'b1;
            case (m_op)
                OP_START: begin
                    case (p)
                        0:       m_sda = 1'b1;
                        1:       m_scl = 1'b1;
                        2:       m_sda = 1'b0;
                        default: m_scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    if (p == 0) begin
                        m_sda = 1'b0;
                        m_scl = 1'b1;
                    end else begin
                        m_sda = 1'b1;
                    end
                end
                OP_WRITE: begin
                    if (p <= WR_LAST_BIT) begin
                        case (p % 3)
                            0: m_sda = (m_shift & MSB_MASK) != 8'h00;
                            1: m_scl = 1'b1;
                            default: begin
                                m_scl = 1'b0;
                                m_shift = m_shift << 1;
                                if (p == WR_LAST_BIT) m_sda = 1'b1;
                            end
                        endcase
                    end else if (p == WR_RELEASE) begin
                        m_sda = 1'b1;
                    end else if (p == WR_ACK_HIGH) begin
                        m_scl = 1'b1;
                    end else begin
                        m_nack = it.sda_in;
                        m_scl = 1'b0;
                    end
                end
                default: begin
                    if (p < RD_ACK_DRIVE) begin
                        if (p % 2 == 0) begin
                            m_scl = 1'b1;
                        end else begin
                            m_shift = {m_shift[6:0], it.sda_in};
                            m_scl = 1'b0;
                        end
                    end else if (p == RD_ACK_DRIVE) begin
                        m_sda = !m_ack_choice;
                    end else if (p == RD_ACK_HIGH) begin
                        m_scl = 1'b1;
                    end else begin
                        m_scl = 1'b0;
                        if (m_ack_choice) m_sda = 1'b1;
                        m_rx = m_shift;
                    end
                end
            endcase
            if (p + 1 >= m_len) begin
                r.done_res = 1'b1;
                m_op = OP_IDLE;
                m_phase = 0;
            end else begin
                m_phase = p + 1;
            end
        end

        r.scl_out = m_scl;
        r.sda_out = m_sda;
        r.read_data = m_rx;
        r.nack = m_nack;
        return r;
    endfunction

    // Plain ticks are mostly kind zero; the unused kinds act the same way.
    function automatic logic [2:0] tick_kind();
        if ($urandom_range(0, 99) < 85) return K_TICK;
        return 3'($urandom_range(5, 7));
    endfunction

    task automatic queue_idle_tick();
        t_in_item it;
        it.kind = tick_kind();
        it.data = 8'($urandom);
        it.drive_ack = 1'($urandom);
        it.sda_in = 1'($urandom);
        tick_queue.push_back(it);
    endtask

    // Queues a command beat followed by the ticks that complete it. The slave
    // drives rx_pattern during read sampling and ack_level at the write ack.
    // At tick inject_at (if in range) a command is issued while busy.
    task automatic queue_command(input logic [2:0] kind, input logic [7:0] data,
                                 input logic dack, input logic [7:0] rx_pattern,
                                 input logic ack_level, input int inject_at);
        t_in_item it;
        int       len;
        len = command_length(kind);
        for (int p = 0; p < len; p++) begin
            it.data = 8'($urandom);
            it.drive_ack = 1'($urandom);
            it.sda_in = 1'($urandom);
            if (p == 0) begin
                it.kind = kind;
                it.data = data;
                it.drive_ack = dack;
            end else if (p == inject_at) begin
                it.kind = 3'($urandom_range(K_START, K_READ));
            end else begin
                it.kind = tick_kind();
            end
            if (kind == K_READ && p < RD_ACK_DRIVE && p % 2 == 1)
                it.sda_in = rx_pattern[7 - p / 2];
            if (kind == K_WRITE && p == LEN_WRITE - 1)
                it.sda_in = ack_level;
            tick_queue.push_back(it);
        end
    endtask

    task automatic compare_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Driver: offers queued beats, idling at a rate that depends on the stage.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_ticks.push_back(bus_tick(in_item));
                n_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (tick_queue.size() != 0 &&
                    $urandom_range(0, 99) >=
                        ((n_accepted * 3 / total_items) == 0 ? 19 :
                         (n_accepted * 3 / total_items) == 1 ? 51 : 0)) begin
                    in_item <= tick_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off mid-run so the engine backs up and stalls its input.
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end else if (!stall_done && n_checked >= total_items / 2) begin
                stall_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
            end
        end
    end

    // Monitor: checks each result beat and applies back-pressure.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_ticks.size() == 0) begin
                    $error("result beat with no expectation pending");
                    fail_count++;
                end else begin
                    want = expected_ticks.pop_front();
                    compare_field("scl_out", want.scl_out, out_item.scl_out);
                    compare_field("sda_out", want.sda_out, out_item.sda_out);
                    compare_field("busy_res", want.busy_res, out_item.busy_res);
                    compare_field("done_res", want.done_res, out_item.done_res);
                    compare_field("read_data", want.read_data, out_item.read_data);
                    compare_field("nack", want.nack, out_item.nack);
                    compare_field("cmd_ignored", want.cmd_ignored, out_item.cmd_ignored);
                end
                n_checked++;
            end
            if (hold_left > 0) begin
                out_ready <= 1'b0;
            end else begin
                out_ready <= $urandom_range(0, 99) >=
                    ((n_checked * 3 / total_items) == 0 ? 51 :
                     (n_checked * 3 / total_items) == 1 ? 19 : 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int target;
        int r;
        int len;
        logic [2:0] kind;

        // Directed part: idle ticks with every kind that does nothing.
        for (int k = 0; k < 4; k++) begin
            tick_queue.push_back('{kind: (k == 0) ? K_TICK : 3'(4 + k), data: 8'hFF,
                                   drive_ack: 1'b1, sda_in: 1'b1});
        end
        queue_command(K_START, 8'h00, 1'b0, 8'h00, 1'b0, -1);
        queue_command(K_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0, -1);
        queue_command(K_WRITE, 8'h00, 1'b1, 8'h00, 1'b1, -1);
        queue_command(K_READ, 8'h00, 1'b1, 8'hFF, 1'b0, -1);
        queue_command(K_READ, 8'hFF, 1'b0, 8'h00, 1'b0, -1);
        // Commands issued while busy, the last one on a final tick.
        queue_command(K_WRITE, 8'hA5, 1'b0, 8'h00, 1'b0, 10);
        queue_command(K_READ, 8'h00, 1'b1, 8'h5A, 1'b0, int'(LEN_READ) - 1);
        queue_command(K_STOP, 8'h00, 1'b0, 8'h00, 1'b0, int'(LEN_STOP) - 1);
        queue_command(K_READ, 8'h00, 1'b0, 8'hC3, 1'b0, -1);
        // A read straight after a start keeps SDA where the start left it.
        queue_command(K_START, 8'h00, 1'b0, 8'h00, 1'b0, -1);
        queue_command(K_READ, 8'h00, 1'b1, 8'h3C, 1'b0, -1);
        // Commands in an order that makes odd conditions on the bus.
        queue_command(K_STOP, 8'h00, 1'b0, 8'h00, 1'b0, -1);
        queue_command(K_STOP, 8'h00, 1'b0, 8'h00, 1'b0, -1);
        queue_command(K_START, 8'h00, 1'b0, 8'h00, 1'b0, 2);
        queue_command(K_START, 8'h00, 1'b0, 8'h00, 1'b0, int'(LEN_START) - 1);
        queue_command(K_WRITE, 8'h01, 1'b1, 8'h00, 1'b1, int'(LEN_WRITE) - 1);
        queue_idle_tick();

        // Random part: mostly complete commands, some noise and broken trains.
        target = tick_queue.size() + RANDOM_ITEMS;
        while (tick_queue.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 85) begin
                kind = 3'($urandom_range(K_START, K_READ));
                len = command_length(kind);
                queue_command(kind, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
                              ($urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : -1);
                repeat ($urandom_range(0, 2)) queue_idle_tick();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    tick_queue.push_back('{kind: 3'($urandom_range(0, 7)), data: 8'($urandom),
                                           drive_ack: 1'($urandom), sda_in: 1'($urandom)});
                end
            end
        end
        total_items = tick_queue.size();

        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;

        while (tick_queue.size() != 0 || in_valid) @(posedge i_clk);
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
